>>> rtl/core/dda_pkg.sv
// Package for the DDA line rasteriser: widths, the queued segment type.
// No dependencies; used by every module of the block.
package dda_pkg;

  localparam int COORD_W     = 6;
  localparam int COLOR_W     = 4;
  localparam int IN_W        = 4 * COORD_W;
  localparam int OUT_W       = 2 * COORD_W + COLOR_W;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] adx;
    logic [COORD_W-1:0] ady;
    logic [COORD_W-1:0] s;
    logic               sx;
    logic               sy;
  } seg_t;

endpackage

>>> rtl/core/dda_front.sv
// Front end: clamps segment end points to the tile and classifies the segment.
// Depends on dda_pkg.
module dda_front #(
  parameter int TILE_SIZE = 64
) (
  input  logic [dda_pkg::IN_W-1:0] tdata,
  output dda_pkg::seg_t            seg
);
  import dda_pkg::*;

  localparam logic [COORD_W-1:0] TILE_MAX = COORD_W'(TILE_SIZE - 1);

  logic [COORD_W-1:0] xs, ys, xe, ye;

  function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
    clamp = (v > TILE_MAX) ? TILE_MAX : v;
  endfunction

  always_comb begin
    xs      = clamp(tdata[0*COORD_W +: COORD_W]);
    ys      = clamp(tdata[1*COORD_W +: COORD_W]);
    xe      = clamp(tdata[2*COORD_W +: COORD_W]);
    ye      = clamp(tdata[3*COORD_W +: COORD_W]);
    seg.xs  = xs;
    seg.ys  = ys;
    seg.sx  = xe < xs;
    seg.sy  = ye < ys;
    seg.adx = seg.sx ? xs - xe : xe - xs;
    seg.ady = seg.sy ? ys - ye : ye - ys;
    seg.s   = (seg.adx > seg.ady) ? seg.adx : seg.ady;
  end

endmodule

>>> rtl/core/dda_queue.sv
// Two-entry queue of classified segments between front and back end.
// Depends on dda_pkg.
module dda_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dda_pkg::seg_t push_seg,
  input  logic          pop,
  output dda_pkg::seg_t head,
  output logic          full,
  output logic          empty
);
  import dda_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  seg_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/dda_div.sv
// Restoring divider, one quotient bit per cycle: |dx|*2^F/s and |dy|*2^F/s.
// Depends on dda_pkg.
module dda_div #(
  parameter int FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  dda_pkg::seg_t        seg,
  output logic                 done,
  output logic [FRAC_BITS:0]   quot_x,
  output logic [FRAC_BITS:0]   quot_y
);
  import dda_pkg::*;

  localparam int NUM_W = COORD_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]   num_x, num_y;
  logic [COORD_W-1:0] rem_x, rem_y, div_s;
  logic [COORD_W:0]   trial_x, trial_y;
  logic               ge_x, ge_y;
  logic [CNT_W-1:0]   cnt;
  logic               busy;

  assign trial_x = {rem_x, num_x[NUM_W-1]};
  assign trial_y = {rem_y, num_y[NUM_W-1]};
  assign ge_x    = trial_x >= {1'b0, div_s};
  assign ge_y    = trial_y >= {1'b0, div_s};
  assign quot_x  = num_x[FRAC_BITS:0];
  assign quot_y  = num_y[FRAC_BITS:0];

  always_ff @(posedge clk) begin
    if (start) begin
      num_x <= {seg.adx, FRAC_BITS'(0)};
      num_y <= {seg.ady, FRAC_BITS'(0)};
      rem_x <= '0;
      rem_y <= '0;
      div_s <= seg.s;
    end else if (busy) begin
      num_x <= {num_x[NUM_W-2:0], ge_x};
      num_y <= {num_y[NUM_W-2:0], ge_y};
      rem_x <= ge_x ? COORD_W'(trial_x - {1'b0, div_s}) : trial_x[COORD_W-1:0];
      rem_y <= ge_y ? COORD_W'(trial_y - {1'b0, div_s}) : trial_y[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/dda_back.sv
// Back end: takes segments from the queue, sets up the increments and
// steps the fixed-point position, one pixel per transaction. Uses dda_pkg, dda_div.
module dda_back #(
  parameter int TILE_SIZE = 64,
  parameter int FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dda_pkg::seg_t               head,
  input  logic                        empty,
  output logic                        pop,
  input  logic [dda_pkg::COLOR_W-1:0] pixel_color,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [dda_pkg::OUT_W-1:0]   m_tdata,
  output logic                        m_tlast
);
  import dda_pkg::*;

  localparam int POS_W = COORD_W + FRAC_BITS + 1;
  localparam int CNT_W = $clog2(TILE_SIZE);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]           state;
  logic [POS_W-1:0]     pos_x, pos_y, step_x, step_y;
  logic [CNT_W-1:0]     steps_left;
  logic                 sign_x, sign_y;
  logic                 div_start, div_done, emit;
  logic [FRAC_BITS:0]   quot_x, quot_y;
  logic [POS_W-1:0]     qx_ext, qy_ext;

  assign pop       = (state == ST_IDLE) && !empty;
  assign div_start = pop && (head.s != '0);
  assign emit      = (state == ST_RUN) && (!m_tvalid || m_tready);
  assign qx_ext    = POS_W'(quot_x);
  assign qy_ext    = POS_W'(quot_y);

  dda_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .seg   (head),
    .done  (div_done),
    .quot_x(quot_x),
    .quot_y(quot_y)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      pos_x      <= {1'b0, head.xs, 1'b1, (FRAC_BITS-1)'(0)};
      pos_y      <= {1'b0, head.ys, 1'b1, (FRAC_BITS-1)'(0)};
      steps_left <= head.s[CNT_W-1:0];
      sign_x     <= head.sx;
      sign_y     <= head.sy;
      step_x     <= '0;
      step_y     <= '0;
    end else if (div_done) begin
      step_x <= sign_x ? POS_W'(0) - qx_ext : qx_ext;
      step_y <= sign_y ? POS_W'(0) - qy_ext : qy_ext;
    end else if (emit && steps_left != '0) begin
      pos_x      <= pos_x + step_x;
      pos_y      <= pos_y + step_y;
      steps_left <= steps_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {pixel_color, pos_y[FRAC_BITS +: COORD_W], pos_x[FRAC_BITS +: COORD_W]};
      m_tlast <= steps_left == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            state <= div_start ? ST_DIV : ST_RUN;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (emit && steps_left == '0) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    emit && steps_left == '0 |=> state == ST_IDLE && m_tvalid && m_tlast)
    else $error("last pixel did not end the segment");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside setup");

  a_pixel_in_tile: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[COORD_W-1:0] <= COORD_W'(TILE_SIZE - 1))
    else $error("pixel x outside tile");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    pop |-> !(state == ST_RUN) && !(state == ST_DIV))
    else $error("segment taken while another is in progress");

endmodule

>>> rtl/core/dda_line_rasterizer.sv
// Top level of the DDA line rasteriser: colour register, front end, queue, back end.
// Depends on dda_pkg, dda_front, dda_queue, dda_back.
//
//   channel   dir  fields (lowest bit up)
//   s_axis    in   tdata: x_start[5:0] y_start[11:6] x_end[17:12] y_end[23:18]
//   m_axis    out  tdata: pixel_x[5:0] pixel_y[11:6] color[15:12]; tlast: last_pixel
//   cfg       in   cfg_we, cfg_wdata: pixel_color[3:0]
//
// A segment of s steps leaves the queue, runs through the bit-serial divider, has its
// increments loaded, then yields s + 1 pixels; with s = 0 divider and load are skipped.
// The queue holds two segments, so input is taken while the back end runs.
// Synchronous reset clears control state and sets the colour to 14.
// A stalled output holds the pixel and the stepper; the divider works on regardless.
module dda_line_rasterizer #(
  parameter int TILE_SIZE = 64,
  parameter int FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [dda_pkg::IN_W-1:0]    s_axis_tdata,   // x_start, y_start, x_end, y_end
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [dda_pkg::OUT_W-1:0]   m_axis_tdata,   // pixel_x, pixel_y, color
  output logic                        m_axis_tlast,
  input  logic                        cfg_we,
  input  logic [dda_pkg::COLOR_W-1:0] cfg_wdata
);
  import dda_pkg::*;

  localparam logic [COLOR_W-1:0] COLOR_RESET = COLOR_W'(14);

  logic [COLOR_W-1:0] pixel_color;
  seg_t               front_seg, head;
  logic               push, pop, full, empty;

  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_color <= COLOR_RESET;
    end else if (cfg_we) begin
      pixel_color <= cfg_wdata;
    end
  end

  dda_front #(
    .TILE_SIZE(TILE_SIZE)
  ) u_front (
    .tdata(s_axis_tdata),
    .seg  (front_seg)
  );

  dda_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_seg(front_seg),
    .pop     (pop),
    .head    (head),
    .full    (full),
    .empty   (empty)
  );

  dda_back #(
    .TILE_SIZE(TILE_SIZE),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .pixel_color(pixel_color),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_tdata    (m_axis_tdata),
    .m_tlast    (m_axis_tlast)
  );

endmodule

>>> tb/sv/dda_line_rasterizer_checker.sv
// Checker for the DDA line rasteriser: predicts the pixels of each segment and the
// colour they carry, and compares them with every output transaction.
// Depends on dda_pkg; instantiated beside the block by dda_line_rasterizer_test.
module dda_line_rasterizer_checker #(
  parameter int TILE_SIZE = 64,
  parameter int FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [dda_pkg::IN_W-1:0]    s_axis_tdata,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [dda_pkg::OUT_W-1:0]   m_axis_tdata,
  input  logic                        m_axis_tlast,
  input  logic                        cfg_we,
  input  logic [dda_pkg::COLOR_W-1:0] cfg_wdata,
  output int                          mismatches,
  output int                          pending_pixels,
  output int                          pixels_checked
);
  import dda_pkg::*;

  localparam int ONE = 1 << FRAC_BITS;

  typedef struct {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COLOR_W-1:0] hue;
    logic               last;
  } pixel_t;

  pixel_t             expected_pixels[$];
  logic [COLOR_W-1:0] pixel_colour;
  int                 fails;
  int                 seen;

  function automatic int tile_coord(input logic [COORD_W-1:0] raw);
    return (int'(raw) >= TILE_SIZE) ? TILE_SIZE - 1 : int'(raw);
  endfunction

  task automatic trace_segment(input logic [IN_W-1:0] seg);
    int xs, ys, xe, ye, dx, dy, adx, ady, span, inc_x, inc_y, fx, fy, k;
    pixel_t p;
    xs = tile_coord(seg[0*COORD_W +: COORD_W]);
    ys = tile_coord(seg[1*COORD_W +: COORD_W]);
    xe = tile_coord(seg[2*COORD_W +: COORD_W]);
    ye = tile_coord(seg[3*COORD_W +: COORD_W]);
    dx = xe - xs;
    dy = ye - ys;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    span = (adx > ady) ? adx : ady;
    inc_x = 0;
    inc_y = 0;
    if (span > 0) begin
      inc_x = (dx * ONE) / span;
      inc_y = (dy * ONE) / span;
    end
    fx = xs * ONE + ONE / 2;
    fy = ys * ONE + ONE / 2;
    for (k = 0; k <= span; k++) begin
      p.px = fx[FRAC_BITS +: COORD_W];
      p.py = fy[FRAC_BITS +: COORD_W];
      p.hue = pixel_colour;
      p.last = (k == span);
      expected_pixels.push_back(p);
      fx += inc_x;
      fy += inc_y;
    end
  endtask

  task automatic check_pixel();
    pixel_t p;
    logic [COORD_W-1:0] got_x, got_y;
    logic [COLOR_W-1:0] got_hue;
    got_x = m_axis_tdata[0 +: COORD_W];
    got_y = m_axis_tdata[COORD_W +: COORD_W];
    got_hue = m_axis_tdata[2*COORD_W +: COLOR_W];
    seen++;
    if (expected_pixels.size() == 0) begin
      $error("unexpected pixel: x %0d y %0d colour %0d last %0b",
             got_x, got_y, got_hue, m_axis_tlast);
      fails++;
      return;
    end
    p = expected_pixels.pop_front();
    if (got_x !== p.px) begin
      $error("pixel_x: expected %0d, got %0d", p.px, got_x);
      fails++;
    end
    if (got_y !== p.py) begin
      $error("pixel_y: expected %0d, got %0d", p.py, got_y);
      fails++;
    end
    if (got_hue !== p.hue) begin
      $error("color: expected %0d, got %0d", p.hue, got_hue);
      fails++;
    end
    if (m_axis_tlast !== p.last) begin
      $error("last_pixel: expected %0b, got %0b", p.last, m_axis_tlast);
      fails++;
    end
  endtask

  initial begin
    fails = 0;
    seen = 0;
    pixel_colour = 4'd14;
    mismatches = 0;
    pending_pixels = 0;
    pixels_checked = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      pixel_colour = 4'd14;
      expected_pixels.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        trace_segment(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_pixel();
      end
      if (cfg_we) begin
        pixel_colour = cfg_wdata;
      end
    end
    mismatches <= fails;
    pending_pixels <= expected_pixels.size();
    pixels_checked <= seen;
  end

endmodule

>>> tb/sv/dda_line_rasterizer_test.sv
// Testbench top for the DDA line rasteriser: clock, reset, segment stimulus with random
// idling on both channels, colour register writes between phases, and the verdict.
// Depends on dda_pkg, dda_line_rasterizer and dda_line_rasterizer_checker.
module dda_line_rasterizer_test;
  import dda_pkg::*;

  localparam int TILE_SIZE   = 64;
  localparam int FRAC_BITS   = 12;
  localparam int PHASES      = 5;
  localparam int PHASE_SEGS  = 56;
  localparam int STALL_LIMIT = 1500;
  localparam int SETTLE      = 40;

  logic               clk;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               m_axis_tlast;
  logic               cfg_we;
  logic [COLOR_W-1:0] cfg_wdata;

  int mismatches;
  int pending_pixels;
  int pixels_checked;
  int segments_sent;
  int colour_writes;
  bit steady;

  dda_line_rasterizer #(
    .TILE_SIZE(TILE_SIZE),
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  dda_line_rasterizer_checker #(
    .TILE_SIZE(TILE_SIZE),
    .FRAC_BITS(FRAC_BITS)
  ) pixel_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .pending_pixels(pending_pixels),
    .pixels_checked(pixels_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COORD_W-1:0] clip(input int v);
    if (v < 0) return '0;
    if (v > 63) return 6'd63;
    return v[COORD_W-1:0];
  endfunction

  task automatic send_segment(input logic [COORD_W-1:0] xs, ys, xe, ye);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ye, xe, ys, xs};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    segments_sent++;
  endtask

  task automatic send_random_segment();
    int kind, d, sx, sy;
    logic [COORD_W-1:0] xs, ys, xe, ye;
    kind = $urandom_range(0, 99);
    xs = COORD_W'($urandom_range(0, 63));
    ys = COORD_W'($urandom_range(0, 63));
    xe = COORD_W'($urandom_range(0, 63));
    ye = COORD_W'($urandom_range(0, 63));
    if (kind >= 55 && kind < 75) begin
      xe = clip(int'(xs) + int'($urandom_range(0, 8)) - 4);
      ye = clip(int'(ys) + int'($urandom_range(0, 8)) - 4);
    end else if (kind >= 75 && kind < 85) begin
      if ($urandom_range(0, 1)) ye = ys;
      else xe = xs;
    end else if (kind >= 85 && kind < 95) begin
      d = $urandom_range(1, 63);
      sx = $urandom_range(0, 1) ? d : -d;
      sy = $urandom_range(0, 1) ? d : -d;
      xe = clip(int'(xs) + sx);
      ye = clip(int'(ys) + sy);
    end else if (kind >= 95) begin
      xe = xs;
      ye = ys;
    end
    send_segment(xs, ys, xe, ye);
  endtask

  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels != 0) @(posedge clk);
  endtask

  task automatic write_colour(input logic [COLOR_W-1:0] hue);
    cfg_we    <= 1'b1;
    cfg_wdata <= hue;
    @(posedge clk);
    cfg_we    <= 1'b0;
    colour_writes++;
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      int gap;
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("dda_line_rasterizer_test: FAIL");
    $finish;
  end

  initial begin
    int ph;
    logic [COLOR_W-1:0] hue;
    segments_sent = 0;
    colour_writes = 0;
    steady = 1'b0;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset colour, extremes, zero length, all octants
    send_segment(0, 0, 0, 0);
    send_segment(63, 63, 63, 63);
    send_segment(0, 0, 63, 0);
    send_segment(63, 63, 0, 63);
    send_segment(0, 0, 0, 63);
    send_segment(63, 63, 63, 0);
    send_segment(0, 0, 63, 63);
    send_segment(63, 63, 0, 0);
    send_segment(63, 0, 0, 63);
    send_segment(0, 63, 63, 0);
    send_segment(0, 0, 63, 1);
    send_segment(5, 60, 6, 0);
    send_segment(10, 20, 13, 50);
    send_segment(40, 10, 3, 17);
    send_segment(7, 7, 8, 8);
    send_segment(21, 42, 42, 21);
    send_segment(1, 62, 62, 2);
    send_segment(33, 33, 34, 33);
    finish_phase();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: hue = '0;
        1: hue = '1;
        default: hue = COLOR_W'($urandom_range(0, 15));
      endcase
      write_colour(hue);
      steady = (ph == 2);
      repeat (PHASE_SEGS) send_random_segment();
      finish_phase();
    end
    steady = 1'b0;

    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d segments and %0d pixels over %0d colour settings plus reset colour.",
             segments_sent, pixels_checked, colour_writes);
    $display("Mismatches: %0d, pixels still awaited: %0d.", mismatches, pending_pixels);
    if (mismatches == 0 && pending_pixels == 0)
      $display("dda_line_rasterizer_test: PASS");
    else
      $display("dda_line_rasterizer_test: FAIL");
    $finish;
  end

endmodule
